>>> rtl/core/ctf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctf_pkg
// Shared types, constants and helpers of the coplanar triple finder: sizes of
// the vector store, command codes, the stored vector and the sequencer states.
// ----------------------------------------------------------------------------
package ctf_pkg;

	// Store capacity and coordinate width
	localparam int MAX_VECTORS = 64;
	localparam int COORD_WIDTH = 16;
	localparam int IN_COORD_W  = 16;
	localparam int EFF_W       = (COORD_WIDTH < IN_COORD_W) ? COORD_WIDTH : IN_COORD_W;

	// Index and count widths
	localparam int IDX_W      = $clog2(MAX_VECTORS);
	localparam int CNT_W      = $clog2(MAX_VECTORS + 1);
	localparam int OUT_IDX_W  = 6;
	localparam int IDX_EXT_W  = (IDX_W > OUT_IDX_W) ? IDX_W : OUT_IDX_W;

	// Determinant widths: cofactor, term, full sum
	localparam int COF_W  = 2 * EFF_W + 1;
	localparam int TERM_W = 3 * EFF_W + 1;
	localparam int DET_W  = 3 * EFF_W + 3;

	// Command codes carried on tuser of the input stream
	typedef enum logic [1:0] {
		CMD_LOAD    = 2'd0,
		CMD_ADVANCE = 2'd1,
		CMD_CLEAR   = 2'd2
	} cmd_e_t;

	// One stored vector
	typedef struct packed {
		logic signed [EFF_W-1:0] z;
		logic signed [EFF_W-1:0] y;
		logic signed [EFF_W-1:0] x;
	} vec_t;

	// Three vectors handed to the determinant unit
	typedef struct packed {
		vec_t c;
		vec_t b;
		vec_t a;
	} triple_t;

	// Sequencer states
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_RD_B = 6'b000010,
		ST_RD_C = 6'b000100,
		ST_CAP  = 6'b001000,
		ST_CALC = 6'b010000,
		ST_EMIT = 6'b100000
	} state_t;

	// Map a store index onto the 6-bit result field
	function automatic logic [OUT_IDX_W-1:0] to_out_idx(input logic [IDX_W-1:0] v);
		logic [IDX_EXT_W-1:0] t;
		t = IDX_EXT_W'(v);
		return t[OUT_IDX_W-1:0];
	endfunction

endpackage

>>> rtl/core/ctf_vec_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctf_vec_mem
// Vector store: one write port and one read port, read data registered, so a
// read address given in one cycle returns its entry in the next.
// ----------------------------------------------------------------------------
module ctf_vec_mem (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [ctf_pkg::IDX_W-1:0]  wr_addr,
	input  ctf_pkg::vec_t              wr_data,
	input  logic [ctf_pkg::IDX_W-1:0]  rd_addr,
	output ctf_pkg::vec_t              rd_data
);
	import ctf_pkg::*;

	vec_t mem_q [MAX_VECTORS];

	// Write one entry per transaction
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

>>> rtl/core/ctf_det.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctf_det
// Exact scalar triple product zero test. Three stages: cofactors of b and c,
// products with the coordinates of a, then the sum compared with zero.
// ----------------------------------------------------------------------------
module ctf_det (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  ctf_pkg::triple_t  in_tri,
	output logic              out_valid,
	output logic              out_zero
);
	import ctf_pkg::*;

	logic                     v_s1, v_s2, v_s3;
	logic signed [COF_W-1:0]  bx_e, by_e, bz_e, cx_e, cy_e, cz_e;
	logic signed [COF_W-1:0]  cof0_s1, cof1_s1, cof2_s1;
	logic signed [EFF_W-1:0]  ax_s1, ay_s1, az_s1;
	logic signed [TERM_W-1:0] t0_s2, t1_s2, t2_s2;
	logic signed [DET_W-1:0]  det_sum;
	logic                     zero_s3;

	// Extend b and c before multiplying
	assign bx_e = COF_W'(in_tri.b.x);
	assign by_e = COF_W'(in_tri.b.y);
	assign bz_e = COF_W'(in_tri.b.z);
	assign cx_e = COF_W'(in_tri.c.x);
	assign cy_e = COF_W'(in_tri.c.y);
	assign cz_e = COF_W'(in_tri.c.z);

	// Valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: cofactors of b x c
	always_ff @(posedge clk) begin
		cof0_s1 <= by_e * cz_e - bz_e * cy_e;
		cof1_s1 <= bz_e * cx_e - bx_e * cz_e;
		cof2_s1 <= bx_e * cy_e - by_e * cx_e;
		ax_s1   <= in_tri.a.x;
		ay_s1   <= in_tri.a.y;
		az_s1   <= in_tri.a.z;
	end

	// Stage 2: weight each cofactor by a
	always_ff @(posedge clk) begin
		t0_s2 <= TERM_W'(ax_s1) * TERM_W'(cof0_s1);
		t1_s2 <= TERM_W'(ay_s1) * TERM_W'(cof1_s1);
		t2_s2 <= TERM_W'(az_s1) * TERM_W'(cof2_s1);
	end

	// Stage 3: sum and test for zero
	assign det_sum = DET_W'(t0_s2) + DET_W'(t1_s2) + DET_W'(t2_s2);

	always_ff @(posedge clk) begin
		zero_s3 <= (det_sum == '0);
	end

	assign out_valid = v_s3;
	assign out_zero  = zero_s3;

	a_det_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> ##3 out_valid)
		else $error("determinant result missing three cycles after start");

endmodule

>>> rtl/core/coplanar_triple_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coplanar_triple_finder
// Loads 3D vectors and walks all index triples i<j<k in order, flagging the
// triples whose scalar triple product is exactly zero.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser carries the command (load, advance, clear), tdata the
//   x, y, z coordinates of a load. A load or clear gives no transaction on the
//   output; loads beyond capacity are dropped.
//   Output stream: one transaction per advance with the triple indices, the
//   coplanar flag in tdata, tlast on the final triple and tuser set when no
//   triple is available (all other fields zero then).
//   An advance that finds a triple reads the three vectors through the single
//   read port of the store, runs the three-stage determinant unit and then
//   fills the output register; the block takes the next command once the
//   output register is filled. An advance with no triple fills the output
//   register directly.
//   Reset empties the store (count zero) and restarts the enumeration.
//   A stalled receiver holds the output register; the block keeps accepting
//   loads and clears, and an advance then waits before the output register
//   until the pending result is taken.
// ----------------------------------------------------------------------------
module coplanar_triple_finder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // coord_x, coord_y, coord_z
	input  logic [1:0]  s_axis_tuser,  // command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // first_index, second_index, third_index, is_coplanar, zero pad
	output logic        m_axis_tlast,  // last
	output logic        m_axis_tuser   // no_triple
);
	import ctf_pkg::*;

	state_t               state_q;
	logic [CNT_W-1:0]     count_q;
	logic [IDX_W-1:0]     idx_one_q, idx_two_q, idx_three_q;
	logic                 done_q;
	logic [IDX_W-1:0]     pend_one_q, pend_two_q, pend_three_q;
	logic                 pend_last_q, pend_none_q, pend_cop_q;
	vec_t                 a_q, b_q;
	logic                 out_valid_q;
	logic [OUT_IDX_W-1:0] out_one_q, out_two_q, out_three_q;
	logic                 out_cop_q, out_last_q, out_none_q;

	logic                 in_fire, out_free;
	cmd_e_t               cmd;
	vec_t                 in_vec, rd_vec;
	logic                 wr_en;
	logic [IDX_W-1:0]     rd_addr;
	triple_t              det_tri;
	logic                 det_valid, det_zero;
	logic [CNT_W-1:0]     ie, je, ke, k1, j1, k2, i1, j2, k3;
	logic [CNT_W-1:0]     ni, nj, nk;
	logic                 avail, is_last;

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign cmd      = cmd_e_t'(s_axis_tuser);
	assign out_free = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);

	// Keep the low coordinate bits, sign carried by the field width
	assign in_vec.x = s_axis_tdata[EFF_W-1:0];
	assign in_vec.y = s_axis_tdata[IN_COORD_W+EFF_W-1:IN_COORD_W];
	assign in_vec.z = s_axis_tdata[2*IN_COORD_W+EFF_W-1:2*IN_COORD_W];

	assign wr_en = in_fire && (cmd == CMD_LOAD) && (count_q < CNT_W'(MAX_VECTORS));

	// Pick the read address for each fetch step
	always_comb begin
		case (state_q)
			ST_RD_B: rd_addr = pend_two_q;
			ST_RD_C: rd_addr = pend_three_q;
			default: rd_addr = idx_one_q;
		endcase
	end

	ctf_vec_mem u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (in_vec),
		.rd_addr (rd_addr),
		.rd_data (rd_vec)
	);

	assign det_tri.a = a_q;
	assign det_tri.b = b_q;
	assign det_tri.c = rd_vec;

	ctf_det u_det (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (state_q == ST_CAP),
		.in_tri    (det_tri),
		.out_valid (det_valid),
		.out_zero  (det_zero)
	);

	// Availability, final triple and successor indices
	always_comb begin
		ie = CNT_W'(idx_one_q);
		je = CNT_W'(idx_two_q);
		ke = CNT_W'(idx_three_q);
		avail   = (count_q >= CNT_W'(3)) && !done_q && (ke < count_q);
		is_last = (ie == count_q - CNT_W'(3)) && (je == count_q - CNT_W'(2))
			&& (ke == count_q - CNT_W'(1));
		k1 = ke + CNT_W'(1);
		j1 = je + CNT_W'(1);
		k2 = j1 + CNT_W'(1);
		i1 = ie + CNT_W'(1);
		j2 = i1 + CNT_W'(1);
		k3 = j2 + CNT_W'(1);
		if (k1 < count_q) begin
			ni = ie;
			nj = je;
			nk = k1;
		end else if (k2 < count_q) begin
			ni = ie;
			nj = j1;
			nk = k2;
		end else begin
			ni = i1;
			nj = j2;
			nk = k3;
		end
	end

	// Sequencer and enumeration state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_one_q   <= IDX_W'(0);
			idx_two_q   <= IDX_W'(1);
			idx_three_q <= IDX_W'(2);
			done_q      <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (cmd)
							CMD_LOAD: begin
								if (wr_en) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							CMD_CLEAR: begin
								count_q     <= '0;
								idx_one_q   <= IDX_W'(0);
								idx_two_q   <= IDX_W'(1);
								idx_three_q <= IDX_W'(2);
								done_q      <= 1'b0;
							end
							CMD_ADVANCE: begin
								if (!avail) begin
									state_q <= ST_EMIT;
								end else begin
									state_q <= ST_RD_B;
									if (is_last) begin
										done_q <= 1'b1;
									end else begin
										idx_one_q   <= ni[IDX_W-1:0];
										idx_two_q   <= nj[IDX_W-1:0];
										idx_three_q <= nk[IDX_W-1:0];
									end
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_RD_B: state_q <= ST_RD_C;
				ST_RD_C: state_q <= ST_CAP;
				ST_CAP:  state_q <= ST_CALC;
				ST_CALC: begin
					if (det_valid) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the triple under evaluation and the fetched vectors
	always_ff @(posedge clk) begin
		if (in_fire && (cmd == CMD_ADVANCE)) begin
			pend_one_q   <= idx_one_q;
			pend_two_q   <= idx_two_q;
			pend_three_q <= idx_three_q;
			pend_last_q  <= avail && is_last;
			pend_none_q  <= !avail;
			pend_cop_q   <= 1'b0;
		end
		if (state_q == ST_RD_B) begin
			a_q <= rd_vec;
		end
		if (state_q == ST_RD_C) begin
			b_q <= rd_vec;
		end
		if ((state_q == ST_CALC) && det_valid) begin
			pend_cop_q <= det_zero;
		end
	end

	// Output register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_EMIT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register: payload, zero fields when no triple
	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && out_free) begin
			out_none_q  <= pend_none_q;
			out_one_q   <= pend_none_q ? '0 : to_out_idx(pend_one_q);
			out_two_q   <= pend_none_q ? '0 : to_out_idx(pend_two_q);
			out_three_q <= pend_none_q ? '0 : to_out_idx(pend_three_q);
			out_cop_q   <= !pend_none_q && pend_cop_q;
			out_last_q  <= !pend_none_q && pend_last_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, out_cop_q, out_three_q, out_two_q, out_one_q};
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_none_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_VECTORS))
		else $error("vector count beyond capacity");

	a_index_order: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_one_q < idx_two_q) && (idx_two_q < idx_three_q))
		else $error("enumeration indices out of order");

	a_no_triple_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0) && !m_axis_tlast)
		else $error("no-triple result with nonzero fields");

endmodule
